[design/fuqd_pkg.sv]
package fuqd_pkg;

  // Characters that steer the decoder.
  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharAmp   = 8'h26;
  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSpace = 8'h20;

  // Largest number of result words that one input byte can cause.
  localparam int unsigned MaxRes = 5;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);

  // Entries in the queue between front and back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    PART_NAME     = 2'd0,
    PART_VALUE    = 2'd1,
    PART_PAIR_END = 2'd2,
    PART_BODY_END = 2'd3
  } part_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       body_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    part_e      part;
    logic       had_equals;
    logic       run_last;
  } out_word_t;

  // All result words of one input byte, in order, in the low slots.
  typedef struct packed {
    logic [CntW-1:0]          count;
    out_word_t [MaxRes-1:0]   slot;
  } bundle_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

  // Returns {valid, value} for a hex digit of either case.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
      return {1'b1, v[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
      return {1'b1, v[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
      return {1'b1, v[3:0]};
    end
    return 5'b0_0000;
  endfunction

  function automatic out_word_t mk_word(input logic [7:0] b, input part_e p,
                                        input logic eq);
    out_word_t w;
    w.out_byte   = b;
    w.part       = p;
    w.had_equals = eq;
    w.run_last   = 1'b0;
    return w;
  endfunction

endpackage

[design/fuqd_front.sv]
module fuqd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  fuqd_pkg::in_word_t in_word_i,
  output logic               push_o,
  output fuqd_pkg::bundle_t  bundle_o
);

  logic       val_q, val_d;
  logic       open_q, open_d;
  logic [1:0] pcnt_q, pcnt_d;
  logic [7:0] pdig_q, pdig_d;

  logic [7:0]                    ch;
  logic [4:0]                    h;
  logic [4:0]                    hp;
  logic [fuqd_pkg::CntW-1:0]     n;
  fuqd_pkg::out_word_t [fuqd_pkg::MaxRes-1:0] slot;
  fuqd_pkg::part_e               cur;

  // Walks the byte through the decode rules and lays its results into slots.
  always_comb begin
    val_d  = val_q;
    open_d = open_q;
    pcnt_d = pcnt_q;
    pdig_d = pdig_q;
    n      = '0;
    slot   = '0;
    ch     = in_word_i.in_byte;
    h      = fuqd_pkg::hex_decode(ch);
    hp     = fuqd_pkg::hex_decode(pdig_q);
    cur    = val_q ? fuqd_pkg::PART_VALUE : fuqd_pkg::PART_NAME;

    if (in_word_i.in_byte == fuqd_pkg::CharAmp) begin
      if (pcnt_d != 2'd0) begin
        slot[n] = fuqd_pkg::mk_word(fuqd_pkg::CharPct, cur, 1'b0);
        n = n + 1'b1;
        if (pcnt_d >= 2'd2) begin
          slot[n] = fuqd_pkg::mk_word(pdig_d, cur, 1'b0);
          n = n + 1'b1;
        end
      end
      pcnt_d = 2'd0;
      pdig_d = 8'h00;
      if (open_d) begin
        slot[n] = fuqd_pkg::mk_word(8'h00, fuqd_pkg::PART_PAIR_END, val_d);
        n = n + 1'b1;
      end
      open_d = 1'b0;
      val_d  = 1'b0;
    end else if (in_word_i.in_byte == fuqd_pkg::CharEq && !val_d) begin
      if (pcnt_d != 2'd0) begin
        slot[n] = fuqd_pkg::mk_word(fuqd_pkg::CharPct, cur, 1'b0);
        n = n + 1'b1;
        if (pcnt_d >= 2'd2) begin
          slot[n] = fuqd_pkg::mk_word(pdig_d, cur, 1'b0);
          n = n + 1'b1;
        end
      end
      pcnt_d = 2'd0;
      pdig_d = 8'h00;
      val_d  = 1'b1;
      open_d = 1'b1;
    end else begin
      if (val_d && in_word_i.in_byte == fuqd_pkg::CharPlus) begin
        ch = fuqd_pkg::CharSpace;
      end
      h      = fuqd_pkg::hex_decode(ch);
      open_d = 1'b1;
      if (pcnt_d == 2'd0) begin
        if (ch == fuqd_pkg::CharPct) begin
          pcnt_d = 2'd1;
        end else begin
          slot[n] = fuqd_pkg::mk_word(ch, cur, 1'b0);
          n = n + 1'b1;
        end
      end else if (pcnt_d == 2'd1) begin
        if (h[4]) begin
          pdig_d = ch;
          pcnt_d = 2'd2;
        end else begin
          slot[n] = fuqd_pkg::mk_word(fuqd_pkg::CharPct, cur, 1'b0);
          n = n + 1'b1;
          pcnt_d = 2'd0;
          if (ch == fuqd_pkg::CharPct) begin
            pcnt_d = 2'd1;
          end else begin
            slot[n] = fuqd_pkg::mk_word(ch, cur, 1'b0);
            n = n + 1'b1;
          end
        end
      end else begin
        if (h[4]) begin
          slot[n] = fuqd_pkg::mk_word({hp[3:0], h[3:0]}, cur, 1'b0);
          n = n + 1'b1;
          pcnt_d = 2'd0;
          pdig_d = 8'h00;
        end else begin
          // A held percent and digit go out verbatim, then the byte is re-examined.
          slot[n] = fuqd_pkg::mk_word(fuqd_pkg::CharPct, cur, 1'b0);
          n = n + 1'b1;
          slot[n] = fuqd_pkg::mk_word(pdig_d, cur, 1'b0);
          n = n + 1'b1;
          pcnt_d = 2'd0;
          pdig_d = 8'h00;
          if (ch == fuqd_pkg::CharPct) begin
            pcnt_d = 2'd1;
          end else begin
            slot[n] = fuqd_pkg::mk_word(ch, cur, 1'b0);
            n = n + 1'b1;
          end
        end
      end
    end

    if (in_word_i.body_last) begin
      cur = val_d ? fuqd_pkg::PART_VALUE : fuqd_pkg::PART_NAME;
      if (pcnt_d != 2'd0) begin
        slot[n] = fuqd_pkg::mk_word(fuqd_pkg::CharPct, cur, 1'b0);
        n = n + 1'b1;
        if (pcnt_d >= 2'd2) begin
          slot[n] = fuqd_pkg::mk_word(pdig_d, cur, 1'b0);
          n = n + 1'b1;
        end
      end
      if (open_d) begin
        slot[n] = fuqd_pkg::mk_word(8'h00, fuqd_pkg::PART_PAIR_END, val_d);
        n = n + 1'b1;
      end
      slot[n] = fuqd_pkg::mk_word(8'h00, fuqd_pkg::PART_BODY_END, 1'b0);
      n = n + 1'b1;
      val_d  = 1'b0;
      open_d = 1'b0;
      pcnt_d = 2'd0;
      pdig_d = 8'h00;
    end
  end

  assign bundle_o.count = n;
  assign bundle_o.slot  = slot;
  assign push_o         = accept_i && (n != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q  <= 1'b0;
      open_q <= 1'b0;
      pcnt_q <= 2'd0;
      pdig_q <= 8'h00;
    end else if (accept_i) begin
      val_q  <= val_d;
      open_q <= open_d;
      pcnt_q <= pcnt_d;
      pdig_q <= pdig_d;
    end
  end

  // An escape never holds more than a percent and one digit.
  a_pcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcnt_q != 2'd3)
    else $error("pending escape count out of range");

endmodule

[design/fuqd_queue.sv]
module fuqd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fuqd_pkg::bundle_t  bundle_i,
  input  logic               pop_i,
  output fuqd_pkg::bundle_t  head_o,
  output fuqd_pkg::q_stat_t  stat_o
);

  fuqd_pkg::bundle_t                  mem_q [fuqd_pkg::QDepth];
  logic [fuqd_pkg::QPtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [fuqd_pkg::QPtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [fuqd_pkg::QCntW-1:0]         cnt_q, cnt_d;

  assign stat_o.full      = (cnt_q == fuqd_pkg::QCntW'(fuqd_pkg::QDepth));
  assign stat_o.not_empty = (cnt_q != '0);
  assign head_o           = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == fuqd_pkg::QPtrW'(fuqd_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == fuqd_pkg::QPtrW'(fuqd_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= bundle_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> stat_o.not_empty)
    else $error("pop from an empty queue");

endmodule

[design/fuqd_back.sv]
module fuqd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fuqd_pkg::bundle_t   head_i,
  input  fuqd_pkg::q_stat_t   stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fuqd_pkg::out_word_t out_word_o
);

  logic [fuqd_pkg::CntW-1:0] idx_q, idx_d;
  logic                      oval_q, oval_d;
  fuqd_pkg::out_word_t       out_q, out_d;
  logic                      load;
  logic                      at_end;

  assign load   = stat_i.not_empty && (!oval_q || !out_stall_i);
  assign at_end = (idx_q == head_i.count - 1'b1);
  assign pop_o  = load && at_end;

  always_comb begin
    idx_d  = idx_q;
    out_d  = out_q;
    oval_d = oval_q && out_stall_i;
    if (load) begin
      out_d          = head_i.slot[idx_q];
      out_d.run_last = at_end;
      oval_d         = 1'b1;
      idx_d          = at_end ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      oval_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = oval_q;
  assign out_word_o  = out_q;

  a_body_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oval_q && out_q.part == fuqd_pkg::PART_BODY_END |-> out_q.run_last)
    else $error("end of body is not the last word of its byte");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oval_q && (out_q.part == fuqd_pkg::PART_PAIR_END ||
               out_q.part == fuqd_pkg::PART_BODY_END) |-> out_q.out_byte == 8'h00)
    else $error("marker word carries a nonzero byte");

endmodule

[design/form_urlencoded_query_decoder.sv]
// Decoder for a form-urlencoded query or fragment body, one raw byte per input word. It
// splits pairs on '&' and each segment on its first '=', turns '+' into a space in values,
// decodes %XX escapes and passes malformed or cut-short escapes through verbatim; each
// non-empty segment closes with an end-of-pair word and the last byte adds an end-of-body
// word. A front stage decodes each byte combinationally into a bundle of zero to five result
// words, which waits in a two-entry queue; a back stage hands the words out one per cycle
// through a registered output unless it stalls. A byte is taken every cycle as long
// as bytes yield one result word on average and the output does not stall, since the back
// stage emits at most one word per cycle; a byte that yields several words holds the back
// stage until all are out, and the input stalls only once the queue fills. The first result
// word of an accepted byte passes through the queue and then the output register. Bytes that
// yield no words (a percent sign, a held hex digit, the first equals sign, an ampersand that
// closes an empty segment) never enter the queue. No clearing pass is needed after reset.
module form_urlencoded_query_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fuqd_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fuqd_pkg::out_word_t out_word_o
);

  logic              accept;
  logic              push;
  logic              pop;
  fuqd_pkg::bundle_t bundle;
  fuqd_pkg::bundle_t head;
  fuqd_pkg::q_stat_t stat;

  // The input stalls only while the queue is full; the word count of the byte does not matter.
  assign in_stall_o = stat.full;
  assign accept     = in_valid_i && !stat.full;

  // Front: decode state and bundling of the result words of one byte.
  fuqd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_word_i (in_word_i),
    .push_o    (push),
    .bundle_o  (bundle)
  );

  // Queue of bundles between the two sides.
  fuqd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .pop_i    (pop),
    .head_o   (head),
    .stat_o   (stat)
  );

  // Back: emits one result word per cycle while the output is not stalled and marks the last word of each byte.
  fuqd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

[sim/form_urlencoded_query_decoder_tb.sv]
`timescale 1ns / 1ps

module form_urlencoded_query_decoder_tb;

  // How long a side idles between its words. WILD draws the full range, LIGHT idles now
  // and then, FLAT never idles, so that back-to-back stretches appear as well.
  typedef enum logic [1:0] {
    PACE_WILD,
    PACE_LIGHT,
    PACE_FLAT
  } pace_e;

  localparam int unsigned MaxGap      = 18;
  localparam int unsigned TargetBytes = 470;
  // A byte reaches the output through the queue and the output register. The drain wait
  // after the last expected word lets any surplus word still in flight show up.
  localparam int unsigned DrainCycles = 40;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  fuqd_pkg::in_word_t  in_word_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  fuqd_pkg::out_word_t out_word_o;

  form_urlencoded_query_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Raw body bytes waiting to be sent, and the decoded words that the decoder still owes us.
  fuqd_pkg::in_word_t  body_bytes_q[$];
  fuqd_pkg::out_word_t decoded_words_q[$];
  int unsigned mismatches = 0;

  // Our own copy of the decoder state.
  logic       dec_in_value;
  logic       dec_seg_open;
  logic [1:0] dec_pend_cnt;
  logic [7:0] dec_pend_digit;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic int unsigned draw_gap(input pace_e pace);
    case (pace)
      PACE_WILD:  return $urandom_range(0, MaxGap);
      PACE_LIGHT: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
      default:    return 0;
    endcase
  endfunction

  //--------------------------------------------------------------------------
  // Decoding predictor
  //--------------------------------------------------------------------------

  function automatic void clear_decoder();
    dec_in_value   = 1'b0;
    dec_seg_open   = 1'b0;
    dec_pend_cnt   = 2'd0;
    dec_pend_digit = 8'h00;
  endfunction

  // Value of a hex digit of either case, or -1 for any other character.
  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  function automatic void expect_word(input logic [7:0] b, input fuqd_pkg::part_e p,
                                      input logic eq);
    fuqd_pkg::out_word_t w;
    w.out_byte   = b;
    w.part       = p;
    w.had_equals = eq;
    w.run_last   = 1'b0;
    decoded_words_q.insert(decoded_words_q.size(), w);
  endfunction

  // A byte of whichever part the segment is in right now.
  function automatic void expect_char(input logic [7:0] b);
    expect_word(b, dec_in_value ? fuqd_pkg::PART_VALUE : fuqd_pkg::PART_NAME, 1'b0);
  endfunction

  // A pending escape that cannot complete comes out verbatim: the percent sign and the
  // held digit, if there is one.
  function automatic void flush_escape();
    if (dec_pend_cnt != 2'd0) begin
      expect_char(fuqd_pkg::CharPct);
      if (dec_pend_cnt >= 2'd2) expect_char(dec_pend_digit);
    end
    dec_pend_cnt   = 2'd0;
    dec_pend_digit = 8'h00;
  endfunction

  function automatic void start_or_emit(input logic [7:0] ch);
    if (ch == fuqd_pkg::CharPct) dec_pend_cnt = 2'd1;
    else expect_char(ch);
  endfunction

  function automatic void decode_char(input logic [7:0] ch);
    int         lo;
    int         hi;
    logic [7:0] full;
    lo = hex_val(ch);
    if (dec_pend_cnt == 2'd0) begin
      start_or_emit(ch);
    end else if (dec_pend_cnt == 2'd1) begin
      if (lo >= 0) begin
        dec_pend_digit = ch;
        dec_pend_cnt   = 2'd2;
      end else begin
        // Bad first digit: the percent goes out and the character is looked at again.
        expect_char(fuqd_pkg::CharPct);
        dec_pend_cnt = 2'd0;
        start_or_emit(ch);
      end
    end else begin
      // A count of three cannot occur; it would behave like two.
      if (lo >= 0) begin
        hi   = hex_val(dec_pend_digit);
        full = {hi[3:0], lo[3:0]};
        expect_char(full);
        dec_pend_cnt   = 2'd0;
        dec_pend_digit = 8'h00;
      end else begin
        flush_escape();
        start_or_emit(ch);
      end
    end
  endfunction

  // Empty segments close silently; others end with a pair marker.
  function automatic void close_segment();
    flush_escape();
    if (dec_seg_open) expect_word(8'h00, fuqd_pkg::PART_PAIR_END, dec_in_value);
    dec_seg_open = 1'b0;
    dec_in_value = 1'b0;
  endfunction

  function automatic void predict_byte(input fuqd_pkg::in_word_t w);
    int unsigned first;
    logic [7:0]  ch;
    first = decoded_words_q.size();
    if (w.in_byte == fuqd_pkg::CharAmp) begin
      close_segment();
    end else if (w.in_byte == fuqd_pkg::CharEq && !dec_in_value) begin
      // Only the first equals sign splits; later ones are plain value bytes.
      flush_escape();
      dec_in_value = 1'b1;
      dec_seg_open = 1'b1;
    end else begin
      ch           = w.in_byte;
      dec_seg_open = 1'b1;
      if (dec_in_value && ch == fuqd_pkg::CharPlus) ch = fuqd_pkg::CharSpace;
      decode_char(ch);
    end
    if (w.body_last) begin
      close_segment();
      expect_word(8'h00, fuqd_pkg::PART_BODY_END, 1'b0);
      clear_decoder();
    end
    // The last word of this byte carries the run marker.
    if (decoded_words_q.size() > first) begin
      decoded_words_q[decoded_words_q.size() - 1].run_last = 1'b1;
    end
  endfunction

  initial clear_decoder();

  //--------------------------------------------------------------------------
  // Stimulus building
  //--------------------------------------------------------------------------

  function automatic void queue_byte(input logic [7:0] b, input logic last);
    fuqd_pkg::in_word_t w;
    w.in_byte   = b;
    w.body_last = last;
    body_bytes_q.insert(body_bytes_q.size(), w);
  endfunction

  // Queues a string; the final character ends the body when asked to.
  function automatic void queue_text(input string s, input logic ends_body);
    for (int i = 0; i < s.len(); i++) begin
      queue_byte(s[i], ends_body && (i == s.len() - 1));
    end
  endfunction

  function automatic logic [7:0] plain_char();
    case ($urandom_range(0, 2))
      0:       return 8'("a") + 8'($urandom_range(0, 25));
      1:       return 8'("A") + 8'($urandom_range(0, 25));
      default: return 8'("0") + 8'($urandom_range(0, 9));
    endcase
  endfunction

  function automatic logic [7:0] hex_char();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  // Content of a name or a value: mostly plain text and good escapes, with plus signs,
  // broken escapes and arbitrary bytes mixed in.
  function automatic void queue_part(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: queue_byte(plain_char(), 1'b0);
        5, 6: begin
          queue_byte(fuqd_pkg::CharPct, 1'b0);
          queue_byte(hex_char(), 1'b0);
          queue_byte(hex_char(), 1'b0);
        end
        7: queue_byte(fuqd_pkg::CharPlus, 1'b0);
        8: begin
          // Escape left short; whatever follows gets re-examined.
          queue_byte(fuqd_pkg::CharPct, 1'b0);
          if ($urandom_range(0, 1) == 1) queue_byte(hex_char(), 1'b0);
        end
        default: queue_byte(8'($urandom_range(0, 255)), 1'b0);
      endcase
    end
  endfunction

  // A well-formed body of a few pairs with random content.
  function automatic void queue_body();
    int unsigned start;
    start = body_bytes_q.size();
    for (int unsigned s = 0; s < $urandom_range(1, 4); s++) begin
      if (s != 0) queue_byte(fuqd_pkg::CharAmp, 1'b0);
      if ($urandom_range(0, 9) == 0) queue_byte(fuqd_pkg::CharAmp, 1'b0);
      queue_part($urandom_range(0, 4));
      if ($urandom_range(0, 4) != 0) queue_byte(fuqd_pkg::CharEq, 1'b0);
      queue_part($urandom_range(0, 5));
    end
    if (body_bytes_q.size() == start) begin
      queue_byte(plain_char(), 1'b1);
    end else begin
      body_bytes_q[body_bytes_q.size() - 1].body_last = 1'b1;
    end
  endfunction

  // Arbitrary bytes with an occasional stray body end.
  function automatic void queue_noise();
    for (int unsigned i = 0; i < $urandom_range(1, 10); i++) begin
      queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
    end
  endfunction

  //--------------------------------------------------------------------------
  // Driver: sends one byte word at a time, waits a drawn number of cycles in between.
  //--------------------------------------------------------------------------

  pace_e       send_pace = PACE_WILD;
  int unsigned send_wait = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
      send_wait  <= 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      // The word on the bus, if any, has just been taken.
      if (in_valid_i) predict_byte(in_word_i);
      if (send_wait != 0) begin
        send_wait  <= send_wait - 1;
        in_valid_i <= 1'b0;
      end else if (body_bytes_q.size() != 0) begin
        in_word_i  <= body_bytes_q.pop_front();
        in_valid_i <= 1'b1;
        send_wait  <= draw_gap(send_pace);
        if ($urandom_range(0, 29) == 0) send_pace = pace_e'($urandom_range(0, 2));
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  //--------------------------------------------------------------------------
  // Monitor: checks each taken word against the oldest decoded word we expect,
  // then stalls for a drawn number of cycles.
  //--------------------------------------------------------------------------

  pace_e       recv_pace = PACE_WILD;
  int unsigned hold_left = 0;

  task automatic check_word(input fuqd_pkg::out_word_t got);
    fuqd_pkg::out_word_t want;
    if (decoded_words_q.size() == 0) begin
      report_mismatch($sformatf("unexpected word byte=%02h part=%0d eq=%b last=%b",
                                got.out_byte, got.part, got.had_equals, got.run_last));
    end else begin
      want = decoded_words_q.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("out_byte %02h, expected %02h", got.out_byte,
                                  want.out_byte));
      if (got.part !== want.part)
        report_mismatch($sformatf("part %0d, expected %0d", got.part, want.part));
      if (got.had_equals !== want.had_equals)
        report_mismatch($sformatf("had_equals %b, expected %b", got.had_equals,
                                  want.had_equals));
      if (got.run_last !== want.run_last)
        report_mismatch($sformatf("run_last %b, expected %b", got.run_last,
                                  want.run_last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        check_word(out_word_o);
        hold_left = draw_gap(recv_pace);
        if ($urandom_range(0, 29) == 0) recv_pace = pace_e'($urandom_range(0, 2));
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  //--------------------------------------------------------------------------
  // Main sequence
  //--------------------------------------------------------------------------

  initial begin
    // Directed bodies. An escaped name with a lowercase digit, then an escape that the
    // end of the body cuts short in the value.
    queue_text("%4f=%A", 1'b1);
    // A segment of only an equals sign followed by a second equals sign as value, an
    // empty segment, a bad escape character, and an escape cut short by an ampersand
    // that is also the last byte.
    queue_text("==&&%g%&", 1'b1);
    // A held digit cut short by the first equals sign, then the byte extremes and a plus
    // sign that turns into a space in the value.
    queue_text("%4=", 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(fuqd_pkg::CharPlus, 1'b1);
    // A plus sign stays as is in a name, and a percent sign after a percent sign starts
    // a fresh escape with decimal digits.
    queue_text("+%%41", 1'b1);

    // Random part: mostly well-formed bodies, with a share of noise.
    while (body_bytes_q.size() < TargetBytes) begin
      if ($urandom_range(0, 7) == 0) queue_noise();
      else queue_body();
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every byte to be taken, then for every decoded word to arrive, then a
    // little longer so that any surplus word shows up as a mismatch.
    while (body_bytes_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (decoded_words_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake. The slowest correct run is well under a millisecond.
  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
